>>> sv/mips_load_store_align_unit_macros.svh
// ---------------------------------------------------------------------------
// MIPS load/store alignment unit assertion macros
// Shared concurrent assertion forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef MIPS_LOAD_STORE_ALIGN_UNIT_MACROS_SVH
`define MIPS_LOAD_STORE_ALIGN_UNIT_MACROS_SVH

// Assertion sampled on the rising clock edge and switched off during reset.
`define MLSAU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mlsau assertion failed");

// Assertion sampled on the rising clock edge that also holds during reset.
`define MLSAU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mlsau assertion failed");

`endif

>>> sv/mlsau_pkg.sv
// ---------------------------------------------------------------------------
// MIPS load/store alignment unit package
// Opcodes, transaction types and the access size table.
// ---------------------------------------------------------------------------
`default_nettype none

package mlsau_pkg;

  localparam logic [63:0] AllOnes  = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] WordMask = 64'h0000_0000_ffff_ffff;

  typedef enum logic [4:0] {
    CMD_LB   = 5'd0,
    CMD_LBU  = 5'd1,
    CMD_LH   = 5'd2,
    CMD_LHU  = 5'd3,
    CMD_LW   = 5'd4,
    CMD_LWU  = 5'd5,
    CMD_LD   = 5'd6,
    CMD_SB   = 5'd7,
    CMD_SH   = 5'd8,
    CMD_SW   = 5'd9,
    CMD_SD   = 5'd10,
    CMD_LDC1 = 5'd11,
    CMD_SDC1 = 5'd12,
    CMD_LWL  = 5'd13,
    CMD_LWR  = 5'd14,
    CMD_LDL  = 5'd15,
    CMD_LDR  = 5'd16,
    CMD_SWL  = 5'd17,
    CMD_SWR  = 5'd18,
    CMD_SDL  = 5'd19,
    CMD_SDR  = 5'd20,
    CMD_LL   = 5'd21,
    CMD_SC   = 5'd22
  } mlsau_cmd_e;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [63:0] vaddr;
    logic [63:0] mem_read_data;
    logic [63:0] reg_value;
    logic        fault;
  } mlsau_req_t;

  typedef struct packed {
    logic [63:0] mem_addr;
    logic [3:0]  mem_bytes;
    logic        reg_write;
    logic [63:0] reg_result;
    logic        store_enable;
    logic [63:0] store_data;
    logic        exc;
  } mlsau_rsp_t;

  function automatic logic [3:0] access_size(input logic [4:0] cmd);
    logic [3:0] bytes;
    bytes = 4'd1;
    case (cmd)
      CMD_LB, CMD_LBU, CMD_SB:                         bytes = 4'd1;
      CMD_LH, CMD_LHU, CMD_SH:                         bytes = 4'd2;
      CMD_LW, CMD_LWU, CMD_SW, CMD_LWL, CMD_LWR,
      CMD_SWL, CMD_SWR, CMD_LL, CMD_SC:                bytes = 4'd4;
      CMD_LD, CMD_SD, CMD_LDC1, CMD_SDC1, CMD_LDL,
      CMD_LDR, CMD_SDL, CMD_SDR:                       bytes = 4'd8;
      default:                                         bytes = 4'd1;
    endcase
    return bytes;
  endfunction

  function automatic logic [63:0] sext32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

endpackage

`default_nettype wire

>>> sv/mips_load_store_align_unit.sv
// ---------------------------------------------------------------------------
// MIPS load/store alignment unit
// Data-side load/store alignment for a big-endian 64-bit MIPS core.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  req     | in        | req_valid_i / req_ready_o | mlsau_req_t req_i
//  rsp     | out       | rsp_valid_o / rsp_ready_i | mlsau_rsp_t rsp_o
//
// One transaction is accepted per cycle while the output is not stalled.
// An input register feeds the alignment logic, whose result is held in the
// output register until it is taken.
// When the output is stalled the input register still takes one transaction.
// Reset clears the valid bits and the link flag.
// ---------------------------------------------------------------------------
`default_nettype none

module mips_load_store_align_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  mlsau_pkg::mlsau_req_t req_i,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output mlsau_pkg::mlsau_rsp_t rsp_o
);
  import mlsau_pkg::*;

  logic       s1_valid_q;
  mlsau_req_t s1_req_q;
  logic       out_valid_q;
  mlsau_rsp_t out_q;
  logic       link_q;
  logic       s1_adv;
  mlsau_rsp_t rsp_d;
  logic       link_set;

  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_ready_i);
  assign req_ready_o = !s1_valid_q || s1_adv;
  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  mlsau_align u_align (
    .req_i       (s1_req_q),
    .link_flag_i (link_q),
    .rsp_o       (rsp_d),
    .link_set_o  (link_set)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      link_q      <= 1'b0;
    end else begin
      if (req_ready_o) begin
        s1_valid_q <= req_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        if (link_set) begin
          link_q <= 1'b1;
        end
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready_o && req_valid_i) begin
      s1_req_q <= req_i;
    end
    if (s1_adv) begin
      out_q <= rsp_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/mlsau_align.sv
// ---------------------------------------------------------------------------
// MIPS load/store alignment datapath
// Extension, left/right merging and store data for one transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module mlsau_align (
  input  mlsau_pkg::mlsau_req_t req_i,
  input  logic                  link_flag_i,
  output mlsau_pkg::mlsau_rsp_t rsp_o,
  output logic                  link_set_o
);
  import mlsau_pkg::*;

  logic [3:0]  bytes;
  logic [63:0] md;
  logic [63:0] rv;
  logic [2:0]  k;
  logic [2:0]  k_lim;
  logic [5:0]  sh_l;
  logic [6:0]  sh_r;
  logic [63:0] m_l;
  logic [63:0] m_r;
  logic        known;
  logic        lr_form;

  assign known   = (req_i.cmd <= CMD_SC);
  assign bytes   = access_size(req_i.cmd);
  assign lr_form = (req_i.cmd >= CMD_LWL) && (req_i.cmd <= CMD_SDR);
  assign rv      = req_i.reg_value;
  assign k_lim   = bytes[3] ? 3'd7 : 3'd3;
  assign k       = req_i.vaddr[2:0] & k_lim;
  assign sh_l    = {k, 3'b000};
  assign sh_r    = {1'b0, k, 3'b000} + 7'd8;
  assign m_l     = (64'd1 << sh_l) - 64'd1;
  assign m_r     = (64'd1 << sh_r[5:0]) - 64'd1;

  always_comb begin
    case (bytes)
      4'd1:    md = req_i.mem_read_data & 64'h0000_0000_0000_00ff;
      4'd2:    md = req_i.mem_read_data & 64'h0000_0000_0000_ffff;
      4'd4:    md = req_i.mem_read_data & WordMask;
      default: md = req_i.mem_read_data;
    endcase
  end

  always_comb begin
    rsp_o              = '0;
    link_set_o         = 1'b0;
    rsp_o.mem_addr     = req_i.vaddr;
    rsp_o.mem_bytes    = bytes;
    if (known && lr_form) begin
      rsp_o.mem_addr[2:0] = req_i.vaddr[2:0] & ~k_lim;
    end
    if (!known) begin
      rsp_o.mem_bytes = 4'd1;
    end else if ((req_i.cmd == CMD_SC) && !link_flag_i) begin
      rsp_o.reg_write = 1'b1;
    end else if (req_i.fault) begin
      rsp_o.exc = 1'b1;
    end else begin
      case (req_i.cmd)
        CMD_LB: begin
          rsp_o.reg_write  = 1'b1;
          rsp_o.reg_result = {{56{md[7]}}, md[7:0]};
        end
        CMD_LBU, CMD_LHU, CMD_LWU, CMD_LD, CMD_LDC1: begin
          rsp_o.reg_write  = 1'b1;
          rsp_o.reg_result = md;
        end
        CMD_LH: begin
          rsp_o.reg_write  = 1'b1;
          rsp_o.reg_result = {{48{md[15]}}, md[15:0]};
        end
        CMD_LW, CMD_LL: begin
          rsp_o.reg_write  = 1'b1;
          rsp_o.reg_result = sext32(md);
          link_set_o       = (req_i.cmd == CMD_LL);
        end
        CMD_SB: begin
          rsp_o.store_enable = 1'b1;
          rsp_o.store_data   = rv & 64'h0000_0000_0000_00ff;
        end
        CMD_SH: begin
          rsp_o.store_enable = 1'b1;
          rsp_o.store_data   = rv & 64'h0000_0000_0000_ffff;
        end
        CMD_SW: begin
          rsp_o.store_enable = 1'b1;
          rsp_o.store_data   = rv & WordMask;
        end
        CMD_SD, CMD_SDC1: begin
          rsp_o.store_enable = 1'b1;
          rsp_o.store_data   = rv;
        end
        CMD_LWL: begin
          rsp_o.reg_write  = 1'b1;
          rsp_o.reg_result = sext32((rv & m_l) | (md << sh_l));
        end
        CMD_LWR: begin
          rsp_o.reg_write = 1'b1;
          if (k == 3'd3) begin
            rsp_o.reg_result = sext32(md);
          end else begin
            rsp_o.reg_result = (rv & ~m_r) | (md >> (7'd32 - sh_r));
          end
        end
        CMD_LDL: begin
          rsp_o.reg_write  = 1'b1;
          rsp_o.reg_result = (rv & m_l) | (md << sh_l);
        end
        CMD_LDR: begin
          rsp_o.reg_write = 1'b1;
          if (k == 3'd7) begin
            rsp_o.reg_result = md;
          end else begin
            rsp_o.reg_result = (rv & ~m_r) | (md >> (7'd64 - sh_r));
          end
        end
        CMD_SWL: begin
          rsp_o.store_enable = 1'b1;
          rsp_o.store_data   = (md & ~(WordMask >> sh_l) & WordMask)
                             | ((rv & WordMask) >> sh_l);
        end
        CMD_SWR: begin
          rsp_o.store_enable = 1'b1;
          if (k == 3'd3) begin
            rsp_o.store_data = rv & WordMask;
          end else begin
            rsp_o.store_data = (md & (WordMask >> sh_r))
                             | ((rv << (7'd32 - sh_r)) & WordMask);
          end
        end
        CMD_SDL: begin
          rsp_o.store_enable = 1'b1;
          rsp_o.store_data   = (md & ~(AllOnes >> sh_l)) | (rv >> sh_l);
        end
        CMD_SDR: begin
          rsp_o.store_enable = 1'b1;
          if (k == 3'd7) begin
            rsp_o.store_data = rv;
          end else begin
            rsp_o.store_data = (md & (AllOnes >> sh_r)) | (rv << (7'd64 - sh_r));
          end
        end
        CMD_SC: begin
          rsp_o.store_enable = 1'b1;
          rsp_o.store_data   = rv & WordMask;
          rsp_o.reg_write    = 1'b1;
          rsp_o.reg_result   = 64'd1;
        end
        default: begin
          rsp_o.reg_write = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/mlsau_chk.sv
// ---------------------------------------------------------------------------
// MIPS load/store alignment unit checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "mips_load_store_align_unit_macros.svh"

module mlsau_chk (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  rsp_valid_o,
  input logic                  rsp_ready_i,
  input mlsau_pkg::mlsau_rsp_t rsp_o
);
  import mlsau_pkg::*;

  logic exc_quiet;
  logic data_clean;
  logic bytes_ok;

  assign exc_quiet  = !rsp_o.exc || (!rsp_o.reg_write && !rsp_o.store_enable);
  assign data_clean = (rsp_o.store_enable || rsp_o.store_data == 64'd0)
                   && (rsp_o.reg_write || rsp_o.reg_result == 64'd0);
  assign bytes_ok   = (rsp_o.mem_bytes == 4'd1) || (rsp_o.mem_bytes == 4'd2)
                   || (rsp_o.mem_bytes == 4'd4) || (rsp_o.mem_bytes == 4'd8);

  `MLSAU_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid_o && !rsp_ready_i |=> rsp_valid_o)
  `MLSAU_ASSERT(a_exc_no_write, clk_i, rst_ni, rsp_valid_o |-> exc_quiet)
  `MLSAU_ASSERT(a_data_zero, clk_i, rst_ni, rsp_valid_o |-> data_clean)
  `MLSAU_ASSERT(a_bytes_legal, clk_i, rst_ni, rsp_valid_o |-> bytes_ok)
  `MLSAU_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !rsp_valid_o)

endmodule

bind mips_load_store_align_unit mlsau_chk u_mlsau_chk (.*);

`default_nettype wire

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// Load/store alignment unit testbench
// Drives memory operations into the alignment unit with random gaps and
// output stalls, works out each result with its own model of the data-side
// alignment, extension and merge rules and of the link flag, and compares
// every result transaction field by field in order of arrival.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mlsau_pkg::*;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned RandomOps  = 1650;

  logic       clk_i;
  logic       rst_ni;
  logic       req_valid_i = 1'b0;
  logic       req_ready_o;
  mlsau_req_t req_i       = '0;
  logic       rsp_valid_o;
  logic       rsp_ready_i = 1'b0;
  mlsau_rsp_t rsp_o;

  mlsau_req_t  pending_ops[$];
  mlsau_rsp_t  predicted_rsps[$];
  mlsau_rsp_t  want;
  logic        link_set   = 1'b0;
  logic        req_fired  = 1'b0;
  logic        rsp_fired  = 1'b0;
  int unsigned op_gap     = 0;
  int unsigned rsp_stall  = 0;
  int unsigned ops_issued = 0;
  int unsigned rsps_seen  = 0;
  int unsigned n_errors   = 0;
  int unsigned cycles     = 0;

  mips_load_store_align_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [63:0] sign_ext(input logic [63:0] v, input int unsigned bits);
    logic [63:0] sign;
    sign = 64'd1 << (bits - 1);
    v    = v & ((sign << 1) - 64'd1);
    return (v ^ sign) - sign;
  endfunction

  // Expected result of one operation; updates the link flag as the unit would.
  function automatic mlsau_rsp_t align_access(input mlsau_req_t r);
    mlsau_rsp_t  o;
    logic [63:0] md;
    logic [63:0] rv;
    logic [63:0] m;
    logic [63:0] dm;
    int unsigned nbytes;
    int unsigned k;
    int unsigned sh;
    o           = '0;
    o.mem_addr  = r.vaddr;
    o.mem_bytes = 4'd1;
    if (r.cmd > CMD_SC) begin
      return o;
    end
    case (r.cmd)
      CMD_LB, CMD_LBU, CMD_SB: nbytes = 1;
      CMD_LH, CMD_LHU, CMD_SH: nbytes = 2;
      CMD_LD, CMD_SD, CMD_LDC1, CMD_SDC1, CMD_LDL, CMD_LDR, CMD_SDL, CMD_SDR: nbytes = 8;
      default: nbytes = 4;
    endcase
    o.mem_bytes = 4'(nbytes);
    md = r.mem_read_data;
    rv = r.reg_value;
    if (nbytes < 8) begin
      md = md & ((64'd1 << (8 * nbytes)) - 64'd1);
    end
    k = 0;
    if (r.cmd >= CMD_LWL && r.cmd <= CMD_SDR) begin
      k          = int'(r.vaddr[2:0]) & (nbytes - 1);
      o.mem_addr = r.vaddr & ~(64'(nbytes) - 64'd1);
    end
    if (r.cmd == CMD_SC && !link_set) begin
      o.reg_write = 1'b1;
    end else if (r.fault) begin
      o.exc = 1'b1;
    end else begin
      case (r.cmd)
        CMD_LB: begin
          o.reg_write = 1'b1;
          o.reg_result = sign_ext(md, 8);
        end
        CMD_LBU, CMD_LHU, CMD_LWU, CMD_LD, CMD_LDC1: begin
          o.reg_write = 1'b1;
          o.reg_result = md;
        end
        CMD_LH: begin
          o.reg_write = 1'b1;
          o.reg_result = sign_ext(md, 16);
        end
        CMD_LW, CMD_LL: begin
          o.reg_write = 1'b1;
          o.reg_result = sign_ext(md, 32);
          if (r.cmd == CMD_LL) begin
            link_set = 1'b1;
          end
        end
        CMD_SB, CMD_SH, CMD_SW, CMD_SD, CMD_SDC1: begin
          o.store_enable = 1'b1;
          o.store_data = rv & ((nbytes < 8) ? ((64'd1 << (8 * nbytes)) - 64'd1) : AllOnes);
        end
        CMD_LWL: begin
          sh = 8 * k;
          m = (64'd1 << sh) - 64'd1;
          o.reg_write = 1'b1;
          o.reg_result = sign_ext((rv & m) | (md << sh), 32);
        end
        CMD_LWR: begin
          o.reg_write = 1'b1;
          if (k == 3) begin
            o.reg_result = sign_ext(md, 32);
          end else begin
            sh = 8 * (k + 1);
            m = (64'd1 << sh) - 64'd1;
            o.reg_result = (rv & ~m) | (md >> (32 - sh));
          end
        end
        CMD_LDL: begin
          sh = 8 * k;
          m = (64'd1 << sh) - 64'd1;
          o.reg_write = 1'b1;
          o.reg_result = (rv & m) | (md << sh);
        end
        CMD_LDR: begin
          o.reg_write = 1'b1;
          if (k == 7) begin
            o.reg_result = md;
          end else begin
            sh = 8 * (k + 1);
            m = (64'd1 << sh) - 64'd1;
            o.reg_result = (rv & ~m) | (md >> (64 - sh));
          end
        end
        CMD_SWL: begin
          sh = 8 * k;
          dm = WordMask >> sh;
          o.store_enable = 1'b1;
          o.store_data = (md & ~dm & WordMask) | ((rv & WordMask) >> sh);
        end
        CMD_SWR: begin
          o.store_enable = 1'b1;
          if (k == 3) begin
            o.store_data = rv & WordMask;
          end else begin
            sh = 8 * (k + 1);
            dm = WordMask >> sh;
            o.store_data = (md & dm) | ((rv << (32 - sh)) & WordMask);
          end
        end
        CMD_SDL: begin
          sh = 8 * k;
          dm = AllOnes >> sh;
          o.store_enable = 1'b1;
          o.store_data = (md & ~dm) | (rv >> sh);
        end
        CMD_SDR: begin
          o.store_enable = 1'b1;
          if (k == 7) begin
            o.store_data = rv;
          end else begin
            sh = 8 * (k + 1);
            dm = AllOnes >> sh;
            o.store_data = (md & dm) | (rv << (64 - sh));
          end
        end
        default: begin
          o.store_enable = 1'b1;
          o.store_data = rv & WordMask;
          o.reg_write = 1'b1;
          o.reg_result = 64'd1;
        end
      endcase
    end
    return o;
  endfunction

  // Calm stretches with no waiting alternate with stretches of random waits.
  function automatic int unsigned draw_wait(input int unsigned seq);
    if ((seq / 128) % 3 == 0) begin
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return AllOnes;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic mlsau_req_t make_op(input logic [4:0] cmd, input logic [63:0] vaddr,
                                         input logic [63:0] md, input logic [63:0] rv,
                                         input logic fault);
    mlsau_req_t r;
    r.cmd           = cmd;
    r.vaddr         = vaddr;
    r.mem_read_data = md;
    r.reg_value     = rv;
    r.fault         = fault;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] exp_val);
    $display("result %0d, %s: got %h, expected %h", rsps_seen, what, seen, exp_val);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_fired <= req_valid_i && req_ready_o;
      rsp_fired <= rsp_valid_o && rsp_ready_i;
      if (req_valid_i && req_ready_o) begin
        predicted_rsps.push_back(align_access(req_i));
      end
      if (rsp_valid_o && rsp_ready_i) begin
        rsps_seen++;
        if (predicted_rsps.size() == 0) begin
          report_mismatch("transaction with nothing outstanding", rsp_o.mem_addr, '0);
        end else begin
          want = predicted_rsps.pop_front();
          if (rsp_o.mem_addr !== want.mem_addr) begin
            report_mismatch("mem_addr", rsp_o.mem_addr, want.mem_addr);
          end
          if (rsp_o.mem_bytes !== want.mem_bytes) begin
            report_mismatch("mem_bytes", 64'(rsp_o.mem_bytes), 64'(want.mem_bytes));
          end
          if (rsp_o.reg_write !== want.reg_write) begin
            report_mismatch("reg_write", 64'(rsp_o.reg_write), 64'(want.reg_write));
          end
          if (rsp_o.reg_result !== want.reg_result) begin
            report_mismatch("reg_result", rsp_o.reg_result, want.reg_result);
          end
          if (rsp_o.store_enable !== want.store_enable) begin
            report_mismatch("store_enable", 64'(rsp_o.store_enable), 64'(want.store_enable));
          end
          if (rsp_o.store_data !== want.store_data) begin
            report_mismatch("store_data", rsp_o.store_data, want.store_data);
          end
          if (rsp_o.exc !== want.exc) begin
            report_mismatch("exc", 64'(rsp_o.exc), 64'(want.exc));
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && !(req_valid_i && !req_fired)) begin
      if (op_gap != 0) begin
        req_valid_i <= 1'b0;
        op_gap--;
      end else if (pending_ops.size() != 0) begin
        req_i       <= pending_ops.pop_front();
        req_valid_i <= 1'b1;
        op_gap = draw_wait(ops_issued);
        ops_issued++;
      end else begin
        req_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_fired) begin
        rsp_stall = draw_wait(rsps_seen);
      end
      if (rsp_stall != 0) begin
        rsp_ready_i <= 1'b0;
        rsp_stall--;
      end else begin
        rsp_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    mlsau_req_t  r;
    logic [63:0] md;
    rst_ni <= 1'b0;
    // Store-conditional before any load-linked, with a fault that must be ignored.
    pending_ops.push_back(make_op(CMD_SC, AllOnes, AllOnes, AllOnes, 1'b1));
    for (int c = 0; c <= int'(CMD_LL); c++) begin
      md = (c % 2 != 0) ? 64'h8080_8080_8080_8080 : AllOnes;
      pending_ops.push_back(make_op(5'(c), (c % 2 != 0) ? '0 : AllOnes, md, ~md,
                                    c == int'(CMD_SB)));
    end
    pending_ops.push_back(make_op(CMD_SC, 64'h0000_0000_0000_0003, '0, AllOnes, 1'b0));
    pending_ops.push_back(make_op(5'd31, AllOnes, AllOnes, AllOnes, 1'b1));
    for (int i = 0; i < RandomOps; i++) begin
      r.cmd = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(23, 31))
                                           : 5'($urandom_range(0, 22));
      r.vaddr         = rand_word();
      r.mem_read_data = rand_word();
      r.reg_value     = rand_word();
      r.fault         = ($urandom_range(0, 7) == 0);
      pending_ops.push_back(r);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || req_valid_i) begin
      @(posedge clk_i);
    end
    while (predicted_rsps.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
